// File: sv/cpd_pkg.sv
// Shared types and constants for the Cartesian-to-polar (degrees) core.
package cpd_pkg;

    localparam int DATA_W  = 24;
    localparam int PHASE_W = 17;
    localparam int GUARD   = 16;
    localparam int XY_W    = DATA_W + GUARD + 3;
    localparam int Z_W     = 29;
    localparam int ATAN_W  = 27;
    localparam int ATAN_N  = 32;
    localparam int ROOT_W  = DATA_W;
    localparam int RAD_W   = 2 * DATA_W;
    localparam int REM_W   = DATA_W + 1;
    localparam int RND_BIT = 11;

    localparam logic [PHASE_W-1:0] PHASE_0    = 17'd0;
    localparam logic [PHASE_W-1:0] PHASE_90   = 17'd23040;
    localparam logic [PHASE_W-1:0] PHASE_180  = 17'd46080;
    localparam logic [PHASE_W-1:0] PHASE_270  = 17'd69120;
    localparam logic [PHASE_W-1:0] PHASE_FULL = 17'd92160;

    localparam logic [Z_W-1:0] Z_180 = 29'd188743680;
    localparam logic [Z_W-1:0] Z_360 = 29'd377487360;

    localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_N] = '{
        27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
        27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
        27'd234682,   27'd117342,   27'd58671,    27'd29335,
        27'd14668,    27'd7334,     27'd3667,     27'd1833,
        27'd917,      27'd458,      27'd229,      27'd115,
        27'd57,       27'd29,       27'd14,       27'd7,
        27'd4,        27'd2,        27'd1,        27'd0,
        27'd0,        27'd0,        27'd0,        27'd0
    };

    typedef struct packed {
        logic signed [DATA_W-1:0] cos_coeff;
        logic signed [DATA_W-1:0] sin_coeff;
    } operand_t;

    typedef struct packed {
        logic [DATA_W-1:0]  amplitude;
        logic [PHASE_W-1:0] phase_deg;
    } result_t;

endpackage

// File: sv/cartesian_to_polar_degrees_core.sv
// Pipelined CORDIC vectoring core: amplitude and phase in 1/256 degree per transaction.
// Done rises once a transaction has passed the front stages, the iteration stages and the finishing stages.
// Throughput: one transaction per cycle; busy stays low and the result is never stalled.
// The depth is set by the CORDIC rotation stages running alongside a bit-per-stage square root.
// Reset clears the valid bits only; transactions in flight at reset are dropped.
module cartesian_to_polar_degrees_core
    import cpd_pkg::*;
#(
    parameter int STAGES = 24
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  operand_t operand,
    output logic     busy,
    output logic     done,
    output result_t  result
);

    localparam int NSTEP = (STAGES > ROOT_W) ? STAGES : ROOT_W;
    localparam int LAT   = NSTEP + 5;

    // front stage 1
    logic                     s1_vld_reg;
    logic [DATA_W-1:0]        s1_mc_reg;
    logic [DATA_W-1:0]        s1_ms_reg;
    logic signed [DATA_W:0]   s1_sy_reg;
    logic                     s1_negc_reg;
    logic                     s1_spec_reg;
    logic [PHASE_W-1:0]       s1_sph_reg;
    logic [DATA_W-1:0]        s1_mc_next;
    logic [DATA_W-1:0]        s1_ms_next;
    logic signed [DATA_W:0]   s1_sy_next;
    logic                     s1_spec_next;
    logic [PHASE_W-1:0]       s1_sph_next;

    // front stage 2
    logic                     s2_vld_reg;
    logic [RAD_W-1:0]         s2_sqc_reg;
    logic [RAD_W-1:0]         s2_sqs_reg;
    logic [DATA_W-1:0]        s2_mc_reg;
    logic signed [DATA_W:0]   s2_sy_reg;
    logic                     s2_negc_reg;
    logic                     s2_spec_reg;
    logic [PHASE_W-1:0]       s2_sph_reg;

    // iteration pipeline
    logic                     vld_reg  [0:NSTEP];
    logic signed [XY_W-1:0]   x_reg    [0:NSTEP-1];
    logic signed [XY_W-1:0]   y_reg    [0:NSTEP-1];
    logic signed [Z_W-1:0]    z_reg    [0:NSTEP];
    logic [RAD_W-1:0]         rad_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0]        root_reg [0:NSTEP];
    logic [REM_W-1:0]         rem_reg  [0:NSTEP];
    logic                     negc_reg [0:NSTEP];
    logic                     spec_reg [0:NSTEP];
    logic [PHASE_W-1:0]       sph_reg  [0:NSTEP];

    // finishing stages
    logic                     f1_vld_reg;
    logic [Z_W-1:0]           f1_z_reg;
    logic [ROOT_W-1:0]        f1_amp_reg;
    logic                     f1_spec_reg;
    logic [PHASE_W-1:0]       f1_sph_reg;
    logic signed [Z_W:0]      f1_zsum;
    logic [Z_W-1:0]           f1_base;
    logic [Z_W-1:0]           f1_z_next;
    logic [ROOT_W-1:0]        f1_amp_next;

    logic                     done_reg;
    result_t                  result_reg;
    logic [Z_W-1:0]           f2_zrnd;
    logic [PHASE_W-1:0]       f2_ph;
    result_t                  result_next;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // stage 1: magnitudes, half-plane fold, axis cases
    always_comb
    begin
        s1_mc_next = operand.cos_coeff[DATA_W-1] ? DATA_W'(-operand.cos_coeff)
                                                 : DATA_W'(operand.cos_coeff);
        s1_ms_next = operand.sin_coeff[DATA_W-1] ? DATA_W'(-operand.sin_coeff)
                                                 : DATA_W'(operand.sin_coeff);
        s1_sy_next = operand.cos_coeff[DATA_W-1]
                   ? -$signed({operand.sin_coeff[DATA_W-1], operand.sin_coeff})
                   : $signed({operand.sin_coeff[DATA_W-1], operand.sin_coeff});
        s1_spec_next = (operand.cos_coeff == '0) || (operand.sin_coeff == '0);
        if (operand.cos_coeff == '0)
        begin
            s1_sph_next = operand.sin_coeff[DATA_W-1] ? PHASE_270 : PHASE_90;
        end
        else
        begin
            s1_sph_next = operand.cos_coeff[DATA_W-1] ? PHASE_180 : PHASE_0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
            s2_vld_reg <= s1_vld_reg;
            vld_reg[0] <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mc_reg   <= s1_mc_next;
        s1_ms_reg   <= s1_ms_next;
        s1_sy_reg   <= s1_sy_next;
        s1_negc_reg <= operand.cos_coeff[DATA_W-1];
        s1_spec_reg <= s1_spec_next;
        s1_sph_reg  <= s1_sph_next;

        s2_sqc_reg  <= s1_mc_reg * s1_mc_reg;
        s2_sqs_reg  <= s1_ms_reg * s1_ms_reg;
        s2_mc_reg   <= s1_mc_reg;
        s2_sy_reg   <= s1_sy_reg;
        s2_negc_reg <= s1_negc_reg;
        s2_spec_reg <= s1_spec_reg;
        s2_sph_reg  <= s1_sph_reg;

        rad_reg[0]  <= s2_sqc_reg + s2_sqs_reg;
        x_reg[0]    <= $signed({{(XY_W-DATA_W-GUARD){1'b0}}, s2_mc_reg, {GUARD{1'b0}}});
        y_reg[0]    <= $signed({{(XY_W-DATA_W-GUARD-1){s2_sy_reg[DATA_W]}}, s2_sy_reg,
                                {GUARD{1'b0}}});
        z_reg[0]    <= '0;
        root_reg[0] <= '0;
        rem_reg[0]  <= '0;
        negc_reg[0] <= s2_negc_reg;
        spec_reg[0] <= s2_spec_reg;
        sph_reg[0]  <= s2_sph_reg;
    end

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_step
        logic signed [XY_W-1:0] x_next;
        logic signed [XY_W-1:0] y_next;
        logic signed [Z_W-1:0]  z_next;
        logic [ROOT_W-1:0]      root_next;
        logic [REM_W-1:0]       rem_next;

        if (k < STAGES)
        begin : g_rot
            localparam logic signed [Z_W-1:0] ATAN_Z = Z_W'(ATAN_TAB[k]);
            always_comb
            begin
                if (!y_reg[k][XY_W-1])
                begin
                    x_next = x_reg[k] + (y_reg[k] >>> k);
                    y_next = y_reg[k] - (x_reg[k] >>> k);
                    z_next = z_reg[k] + ATAN_Z;
                end
                else
                begin
                    x_next = x_reg[k] - (y_reg[k] >>> k);
                    y_next = y_reg[k] + (x_reg[k] >>> k);
                    z_next = z_reg[k] - ATAN_Z;
                end
            end
        end
        else
        begin : g_rot_hold
            assign x_next = x_reg[k];
            assign y_next = y_reg[k];
            assign z_next = z_reg[k];
        end

        if (k < ROOT_W)
        begin : g_sqrt
            logic [REM_W+1:0] rem_sh;
            logic [REM_W+1:0] trial;
            assign rem_sh = {rem_reg[k], rad_reg[k][RAD_W-1-2*k -: 2]};
            assign trial  = {1'b0, root_reg[k], 2'b01};
            always_comb
            begin
                if (rem_sh >= trial)
                begin
                    rem_next  = REM_W'(rem_sh - trial);
                    root_next = {root_reg[k][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh[REM_W-1:0];
                    root_next = {root_reg[k][ROOT_W-2:0], 1'b0};
                end
            end
            if (k + 1 < ROOT_W)
            begin : g_rad
                always_ff @(posedge clk)
                begin
                    rad_reg[k+1] <= rad_reg[k];
                end
            end
        end
        else
        begin : g_sqrt_hold
            assign rem_next  = rem_reg[k];
            assign root_next = root_reg[k];
        end

        if (k + 1 < NSTEP)
        begin : g_xy
            always_ff @(posedge clk)
            begin
                x_reg[k+1] <= x_next;
                y_reg[k+1] <= y_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            z_reg[k+1]    <= z_next;
            root_reg[k+1] <= root_next;
            rem_reg[k+1]  <= rem_next;
            negc_reg[k+1] <= negc_reg[k];
            spec_reg[k+1] <= spec_reg[k];
            sph_reg[k+1]  <= sph_reg[k];
        end
    end

    // finish 1: unfold half plane, wrap negative angle, round the root
    always_comb
    begin
        if (negc_reg[NSTEP])
        begin
            f1_base = Z_180;
        end
        else if (z_reg[NSTEP][Z_W-1])
        begin
            f1_base = Z_360;
        end
        else
        begin
            f1_base = '0;
        end
        f1_zsum     = $signed({z_reg[NSTEP][Z_W-1], z_reg[NSTEP]}) + $signed({1'b0, f1_base});
        f1_z_next   = f1_zsum[Z_W-1:0];
        f1_amp_next = root_reg[NSTEP]
                    + ROOT_W'(rem_reg[NSTEP] > {1'b0, root_reg[NSTEP]});
    end

    // finish 2: round to 1/256 degree, wrap 360 to 0, select axis cases
    always_comb
    begin
        f2_zrnd = f1_z_reg + Z_W'(1 << RND_BIT);
        f2_ph   = f2_zrnd[Z_W-1 -: PHASE_W];
        result_next.amplitude = f1_amp_reg;
        if (f1_spec_reg)
        begin
            result_next.phase_deg = f1_sph_reg;
        end
        else if (f2_ph == PHASE_FULL)
        begin
            result_next.phase_deg = PHASE_0;
        end
        else
        begin
            result_next.phase_deg = f2_ph;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            f1_vld_reg <= vld_reg[NSTEP];
            done_reg   <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_z_reg    <= f1_z_next;
        f1_amp_reg  <= f1_amp_next;
        f1_spec_reg <= spec_reg[NSTEP];
        f1_sph_reg  <= sph_reg[NSTEP];
        result_reg  <= result_next;
    end

    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("transaction did not complete after fixed latency");

    a_phase_range : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.phase_deg < PHASE_FULL)
        else $error("phase out of range");

    a_zero_vector : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.amplitude == '0 |-> result.phase_deg == PHASE_90)
        else $error("zero amplitude without 90 degree phase");

endmodule
